>>> hdl/lodc_pkg.sv
`default_nettype none

package lodc_pkg;

  localparam int unsigned MAX_LOCKS_DEF   = 32;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned LOCK_ID_W       = 5;
  localparam int unsigned DEPTH_W         = 5;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_CYCLE    = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_HALTED   = 3'd4,
    STAT_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    STATE_IDLE,
    STATE_REDUCE,
    STATE_STACK,
    STATE_EDGE,
    STATE_REACH,
    STATE_DONE
  } state_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [LOCK_ID_W-1:0] lock_id;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [DEPTH_W-1:0] held_depth;
  } out_item_t;

  // status of the reachability unit toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } reach_stat_t;

endpackage

`default_nettype wire

>>> hdl/lock_order_deadlock_checker.sv
// steps: a halted item, a release on an empty stack, a first acquire or a full stack
//   end after the id is reduced; a release or an acquire of the top lock also reads the
//   stack top; an acquire along a known edge then reads the top lock's edge row; a new edge
//   is recorded and then walked from the new lock; the id is first reduced by MAX_LOCKS
// throughput: one item at a time; a new item is taken only once the last result is handed on
// reset: empty stack, no halt, every order edge reads as clear; ready at once
`default_nettype none

module lock_order_deadlock_checker #(
  parameter int unsigned MAX_LOCKS   = lodc_pkg::MAX_LOCKS_DEF,
  parameter int unsigned STACK_DEPTH = lodc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire lodc_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lodc_pkg::out_item_t      out_item_o
);

  localparam int unsigned ID_W  = $clog2(MAX_LOCKS);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  lodc_pkg::state_e  state_q, state_d;
  lodc_pkg::status_e status_q, status_d;
  lodc_pkg::cmd_e    cmd_q;

  logic [lodc_pkg::LOCK_ID_W-1:0]      red_q, red_d;
  logic [ID_W+lodc_pkg::LOCK_ID_W-1:0] red_ext;
  logic [ID_W-1:0]                     id;
  logic                                red_ge;
  logic [ID_W-1:0]                     top_q, top_d;
  logic [CNT_W-1:0]                    count_q, count_d;
  logic [CNT_W-1:0]                    cnt_m1;
  logic [CNT_W+lodc_pkg::DEPTH_W-1:0]  depth_ext;
  logic                                halted_q, halted_d;
  logic                                stack_full;
  logic                                stack_empty;

  logic [MAX_LOCKS-1:0] row_valid_q, row_valid_d;
  logic                 rd_valid_q;

  logic             stk_we, stk_re;
  logic [ID_W-1:0]  stk_rdata;
  logic [SA_W-1:0]  stk_waddr, stk_raddr;

  logic                 edge_we, edge_re;
  logic [ID_W-1:0]      edge_raddr;
  logic [MAX_LOCKS-1:0] edge_wdata, edge_rdata, edge_row, id_bit;

  logic                  reach_start, reach_re;
  logic [ID_W-1:0]       reach_raddr;
  lodc_pkg::reach_stat_t reach_stat;

  logic                out_free;
  logic                out_valid_q;
  lodc_pkg::out_item_t out_item_q;

  assign red_ext     = {{ID_W{1'b0}}, red_q};
  assign id          = ID_W'(red_ext);
  assign red_ge      = {2'b00, red_q} >= 7'(MAX_LOCKS);
  assign cnt_m1      = count_q - CNT_W'(1);
  assign depth_ext   = {{lodc_pkg::DEPTH_W{1'b0}}, count_q};
  assign stack_full  = count_q >= CNT_W'(STACK_DEPTH);
  assign stack_empty = count_q == '0;
  assign edge_row    = edge_rdata & {MAX_LOCKS{rd_valid_q}};
  assign id_bit      = {{(MAX_LOCKS-1){1'b0}}, 1'b1} << id;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign in_stall_o  = state_q != lodc_pkg::STATE_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lodc_pkg::STATE_IDLE: begin
        if (in_valid_i) begin
          state_d = lodc_pkg::STATE_REDUCE;
        end
      end
      lodc_pkg::STATE_REDUCE: begin
        if (!red_ge) begin
          if (halted_q) begin
            state_d = lodc_pkg::STATE_DONE;
          end else if (cmd_q == lodc_pkg::CMD_ACQUIRE) begin
            state_d = (stack_full || stack_empty) ? lodc_pkg::STATE_DONE
                                                  : lodc_pkg::STATE_STACK;
          end else begin
            state_d = stack_empty ? lodc_pkg::STATE_DONE : lodc_pkg::STATE_STACK;
          end
        end
      end
      lodc_pkg::STATE_STACK: begin
        if (cmd_q == lodc_pkg::CMD_RELEASE || stk_rdata == id) begin
          state_d = lodc_pkg::STATE_DONE;
        end else begin
          state_d = lodc_pkg::STATE_EDGE;
        end
      end
      lodc_pkg::STATE_EDGE: begin
        state_d = edge_row[id] ? lodc_pkg::STATE_DONE : lodc_pkg::STATE_REACH;
      end
      lodc_pkg::STATE_REACH: begin
        if (reach_stat.done) begin
          state_d = lodc_pkg::STATE_DONE;
        end
      end
      lodc_pkg::STATE_DONE: begin
        if (out_free) begin
          state_d = lodc_pkg::STATE_IDLE;
        end
      end
      default: state_d = lodc_pkg::STATE_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    red_d       = red_q;
    top_d       = top_q;
    status_d    = status_q;
    count_d     = count_q;
    halted_d    = halted_q;
    row_valid_d = row_valid_q;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = count_q[SA_W-1:0];
    stk_raddr   = cnt_m1[SA_W-1:0];
    edge_we     = 1'b0;
    edge_wdata  = edge_row | id_bit;
    reach_start = 1'b0;
    case (state_q)
      lodc_pkg::STATE_IDLE: begin
        red_d = in_item_i.lock_id;
      end
      lodc_pkg::STATE_REDUCE: begin
        status_d = lodc_pkg::STAT_OK;
        if (red_ge) begin
          red_d = red_q - lodc_pkg::LOCK_ID_W'(MAX_LOCKS);
        end else if (halted_q) begin
          status_d = lodc_pkg::STAT_HALTED;
        end else if (cmd_q == lodc_pkg::CMD_ACQUIRE) begin
          if (stack_full) begin
            status_d = lodc_pkg::STAT_OVERFLOW;
          end else if (stack_empty) begin
            stk_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            stk_re = 1'b1;
          end
        end else begin
          if (stack_empty) begin
            status_d = lodc_pkg::STAT_EMPTY;
            halted_d = 1'b1;
          end else begin
            stk_re = 1'b1;
          end
        end
      end
      lodc_pkg::STATE_STACK: begin
        top_d = stk_rdata;
        if (cmd_q == lodc_pkg::CMD_RELEASE) begin
          if (stk_rdata != id) begin
            status_d = lodc_pkg::STAT_MISMATCH;
            halted_d = 1'b1;
          end else begin
            count_d = cnt_m1;
          end
        end else if (stk_rdata == id) begin
          stk_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      lodc_pkg::STATE_EDGE: begin
        if (edge_row[id]) begin
          stk_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end else begin
          // record the new order edge, then look for a path back to the top lock
          edge_we            = 1'b1;
          row_valid_d[top_q] = 1'b1;
          reach_start        = 1'b1;
        end
      end
      lodc_pkg::STATE_REACH: begin
        if (reach_stat.done) begin
          if (reach_stat.found) begin
            status_d = lodc_pkg::STAT_CYCLE;
            halted_d = 1'b1;
          end else begin
            stk_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      lodc_pkg::STATE_DONE: begin
        status_d = status_q;
      end
      default: begin
        status_d = status_q;
      end
    endcase
  end

  // edge memory read port: top row during the stack step, otherwise the walk
  assign edge_re    = (state_q == lodc_pkg::STATE_STACK) || reach_re;
  assign edge_raddr = (state_q == lodc_pkg::STATE_STACK) ? stk_rdata : reach_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lodc_pkg::STATE_IDLE;
      count_q     <= '0;
      halted_q    <= 1'b0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      halted_q    <= halted_d;
      row_valid_q <= row_valid_d;
      if (edge_re) begin
        rd_valid_q <= row_valid_q[edge_raddr];
      end
      out_valid_q <= ((state_q == lodc_pkg::STATE_DONE) && out_free) ||
                     (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lodc_pkg::STATE_IDLE && in_valid_i) begin
      cmd_q <= in_item_i.cmd;
    end
    red_q    <= red_d;
    top_q    <= top_d;
    status_q <= status_d;
    if (state_q == lodc_pkg::STATE_DONE && out_free) begin
      out_item_q.status     <= status_q;
      out_item_q.held_depth <= depth_ext[lodc_pkg::DEPTH_W-1:0];
    end
  end

  lodc_ram #(
    .WIDTH (ID_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (id),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  lodc_ram #(
    .WIDTH (MAX_LOCKS),
    .DEPTH (MAX_LOCKS)
  ) u_edges (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (top_q),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  lodc_reach #(
    .MAX_LOCKS (MAX_LOCKS)
  ) u_reach (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (reach_start),
    .start_id_i  (id),
    .target_id_i (top_q),
    .rd_en_o     (reach_re),
    .rd_addr_o   (reach_raddr),
    .rd_data_i   (edge_row),
    .stat_o      (reach_stat)
  );

endmodule

`default_nettype wire

>>> hdl/lodc_ram.sv
`default_nettype none

module lodc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/lodc_reach.sv
`default_nettype none

module lodc_reach #(
  parameter int unsigned MAX_LOCKS = lodc_pkg::MAX_LOCKS_DEF,
  localparam int unsigned ID_W = $clog2(MAX_LOCKS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [ID_W-1:0]      start_id_i,
  input  wire logic [ID_W-1:0]      target_id_i,
  output logic                      rd_en_o,
  output logic      [ID_W-1:0]      rd_addr_o,
  input  wire logic [MAX_LOCKS-1:0] rd_data_i,
  output lodc_pkg::reach_stat_t     stat_o
);

  logic [MAX_LOCKS-1:0] seen_q, seen_d;
  logic [MAX_LOCKS-1:0] pend_q, pend_d;
  logic [MAX_LOCKS-1:0] merged;
  logic [MAX_LOCKS-1:0] pick;
  logic [MAX_LOCKS-1:0] start_bit;
  logic [ID_W-1:0]      pick_idx;
  logic [ID_W-1:0]      target_q;
  logic                 inflight_q;
  logic                 busy_q;
  logic                 done;

  // one row is read per cycle while any lock is pending; rows are merged lowest pending lock first
  always_comb begin
    merged    = inflight_q ? rd_data_i : '0;
    pick      = pend_q & (~pend_q + 1'b1);
    pick_idx  = '0;
    for (int i = 0; i < MAX_LOCKS; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | ID_W'(i);
      end
    end
    pend_d    = (pend_q & ~pick) | (merged & ~seen_q);
    seen_d    = seen_q | merged;
    start_bit = {{(MAX_LOCKS-1){1'b0}}, 1'b1} << start_id_i;
    done      = busy_q && (pend_q == '0) && !inflight_q;
  end

  assign rd_en_o   = busy_q && (pend_q != '0);
  assign rd_addr_o = pick_idx;

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done;
  assign stat_o.found = seen_q[target_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      inflight_q <= 1'b0;
      seen_q     <= '0;
      pend_q     <= '0;
    end else if (start_i) begin
      busy_q     <= 1'b1;
      inflight_q <= 1'b0;
      seen_q     <= start_bit;
      pend_q     <= start_bit;
    end else if (busy_q) begin
      inflight_q <= rd_en_o;
      seen_q     <= seen_d;
      pend_q     <= pend_d;
      if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      target_q <= target_id_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lodc_checker.sv
`default_nettype none

module lodc_checker #(
  parameter int unsigned STACK_DEPTH = lodc_pkg::STACK_DEPTH_DEF
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire lodc_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire lodc_pkg::out_item_t out_item_o
);

  logic out_xfer;
  logic halt_seen_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  // a fault result makes every later result report halted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_seen_q <= 1'b0;
    end else if (out_xfer && (out_item_o.status == lodc_pkg::STAT_CYCLE ||
                              out_item_o.status == lodc_pkg::STAT_EMPTY ||
                              out_item_o.status == lodc_pkg::STAT_MISMATCH)) begin
      halt_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the item finished");

  a_sticky_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && halt_seen_q |-> out_item_o.status == lodc_pkg::STAT_HALTED)
    else $error("result after a fault is not halted");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (STACK_DEPTH > 31) || (out_item_o.held_depth <= STACK_DEPTH))
    else $error("held depth beyond stack size");

endmodule

bind lock_order_deadlock_checker lodc_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_lodc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
